[design/krt_pkg.sv]
// shared types, sizes and codes for the keyed record table
// no dependencies; imported by every module of the block
package krt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_READ = 2'd2,
    MODE_LIST = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP       = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_AT_MIN    = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] key_id;
    logic [7:0]  in_year;
    logic [15:0] in_course_a;
    logic [7:0]  in_grade_a;
    logic [15:0] in_course_b;
    logic [7:0]  in_grade_b;
    logic [15:0] in_course_c;
    logic [7:0]  in_grade_c;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  used_count;
    logic        is_full;
    logic [31:0] out_id;
    logic [7:0]  out_year;
    logic [15:0] out_course_a;
    logic [7:0]  out_grade_a;
    logic [15:0] out_course_b;
    logic [7:0]  out_grade_b;
    logic [15:0] out_course_c;
    logic [7:0]  out_grade_c;
    logic        last_item;
  } out_t;

  // one stored row
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [7:0]  grade_a;
    logic [7:0]  grade_b;
    logic [7:0]  grade_c;
    logic [15:0] course_a;
    logic [15:0] course_b;
    logic [15:0] course_c;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[design/krt_mem.sv]
// record memory: one write port, one read port with registered data
// depends on krt_pkg for the row and request types
module krt_mem import krt_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rdata
);

  rec_t mem [CAPACITY];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/krt_ctrl.sv]
// sequencer: key scan, row shifting, list walk and result register
// depends on krt_pkg; drives the record memory in krt_mem
module krt_ctrl import krt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_t        in_data,
  input  logic [4:0] min_keep,
  output logic       busy,
  output logic       out_valid,
  output out_t       out_data,
  output mem_req_t   mem_req,
  input  rec_t       mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_t;

  state_t           state_r, state_nxt;
  in_t              item_r, item_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ridx_r, ridx_nxt;
  logic [CNT_W-1:0] cidx_r, cidx_nxt;
  logic [CNT_W-1:0] nleft_r, nleft_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             hit;
  logic             is_add;
  out_t             res;

  function automatic logic [4:0] sat_cnt(input logic [CNT_W-1:0] c);
    if (CMP_W'(c) > CMP_W'(31)) begin
      sat_cnt = 5'd31;
    end else begin
      sat_cnt = 5'(c);
    end
  endfunction

  function automatic out_t make_result(input status_t st, input logic [CNT_W-1:0] c,
                                       input logic last);
    out_t r;
    r            = '0;
    r.status     = st;
    r.used_count = sat_cnt(c);
    r.is_full    = (c >= CNT_W'(CAPACITY));
    r.last_item  = last;
    return r;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    ridx_nxt      = ridx_r;
    cidx_nxt      = cidx_r;
    nleft_nxt     = nleft_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    res           = '0;
    mem_req       = '0;
    mem_req.raddr = ridx_r[IDX_W-1:0];
    hit           = cmp_vld_r && (mem_rdata.key == item_r.key_id);
    is_add        = (item_r.mode == MODE_ADD);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_CHECK;
        end
      end

      // early refusals, then start the walk
      S_CHECK: begin
        ridx_nxt = '0;
        case (item_r.mode)
          MODE_ADD: begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_result(ST_FULL, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          MODE_DEL: begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_result(ST_EMPTY, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end else if (CMP_W'(count_r) <= CMP_W'(min_keep)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_result(ST_AT_MIN, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          MODE_READ: begin
            state_nxt = S_SCAN;
          end
          MODE_LIST: begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_result(ST_EMPTY, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end else begin
              state_nxt = S_LIST;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // one key compare per cycle against the registered read data
      S_SCAN: begin
        if (hit) begin
          case (item_r.mode)
            MODE_ADD: begin
              out_valid_nxt = 1'b1;
              out_nxt       = make_result(ST_DUP, count_r, 1'b1);
              state_nxt     = S_IDLE;
            end
            MODE_DEL: begin
              ridx_nxt  = CNT_W'(cidx_r + 1'b1);
              nleft_nxt = CNT_W'(count_r - cidx_r - 1'b1);
              state_nxt = S_SHIFT;
            end
            MODE_READ: begin
              res              = make_result(ST_OK, count_r, 1'b1);
              res.out_id       = mem_rdata.key;
              res.out_year     = mem_rdata.year;
              res.out_course_a = mem_rdata.course_a;
              res.out_grade_a  = mem_rdata.grade_a;
              res.out_course_b = mem_rdata.course_b;
              res.out_grade_b  = mem_rdata.grade_b;
              res.out_course_c = mem_rdata.course_c;
              res.out_grade_c  = mem_rdata.grade_c;
              out_valid_nxt    = 1'b1;
              out_nxt          = res;
              state_nxt        = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end else if (ridx_r < count_r) begin
          cidx_nxt    = ridx_r;
          cmp_vld_nxt = 1'b1;
          ridx_nxt    = CNT_W'(ridx_r + 1'b1);
        end else if (!cmp_vld_r) begin
          // every held key compared, no match
          if (is_add) begin
            ridx_nxt  = CNT_W'(count_r - 1'b1);
            nleft_nxt = count_r;
            state_nxt = S_SHIFT;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = make_result(ST_NOT_FOUND, count_r, 1'b1);
            state_nxt     = S_IDLE;
          end
        end
      end

      // move rows one place: toward the back for add, toward the front for delete
      S_SHIFT: begin
        if (cmp_vld_r) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = mem_rdata;
          if (is_add) begin
            mem_req.waddr = IDX_W'(cidx_r + 1'b1);
          end else begin
            mem_req.waddr = IDX_W'(cidx_r - 1'b1);
          end
        end
        if (nleft_r != '0) begin
          cidx_nxt    = ridx_r;
          cmp_vld_nxt = 1'b1;
          nleft_nxt   = CNT_W'(nleft_r - 1'b1);
          if (is_add) begin
            ridx_nxt = CNT_W'(ridx_r - 1'b1);
          end else begin
            ridx_nxt = CNT_W'(ridx_r + 1'b1);
          end
        end else if (!cmp_vld_r) begin
          if (is_add) begin
            mem_req.we             = 1'b1;
            mem_req.waddr          = '0;
            mem_req.wdata.key      = item_r.key_id;
            mem_req.wdata.year     = item_r.in_year;
            mem_req.wdata.grade_a  = item_r.in_grade_a;
            mem_req.wdata.grade_b  = item_r.in_grade_b;
            mem_req.wdata.grade_c  = item_r.in_grade_c;
            mem_req.wdata.course_a = item_r.in_course_a;
            mem_req.wdata.course_b = item_r.in_course_b;
            mem_req.wdata.course_c = item_r.in_course_c;
            count_nxt              = CNT_W'(count_r + 1'b1);
          end else begin
            count_nxt = CNT_W'(count_r - 1'b1);
          end
          out_valid_nxt = 1'b1;
          out_nxt       = make_result(ST_OK, count_nxt, 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      // one id per cycle, in table order
      S_LIST: begin
        if (cmp_vld_r) begin
          res           = make_result(ST_OK, count_r,
                                      cidx_r == CNT_W'(count_r - 1'b1));
          res.out_id    = mem_rdata.key;
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          if (res.last_item) begin
            state_nxt = S_IDLE;
          end
        end
        if (ridx_r < count_r) begin
          cidx_nxt    = ridx_r;
          cmp_vld_nxt = 1'b1;
          ridx_nxt    = CNT_W'(ridx_r + 1'b1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      ridx_r      <= ridx_nxt;
      cidx_r      <= cidx_nxt;
      nleft_r     <= nleft_nxt;
      out_r       <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/keyed_record_table_core.sv]
// top level of the keyed record table: config register, sequencer, record memory
// depends on krt_pkg, krt_mem and krt_ctrl
//
//  channel  ports                          direction  handshake
//  in       start, busy, in_data           in         beat taken when start && !busy
//  out      out_valid, out_data            out        one-cycle strobe, no back-pressure
//  cfg      cfg_valid, cfg_ready, cfg_data in         beat taken when cfg_valid && cfg_ready
//
// command beat to final result strobe with N >= 1 rows held: add scans the keys, then every
// row moves back; delete scans, then rows after the hit move forward; read scans; list walks
// all rows; refusals precede the scan; the single memory read port gives one row per cycle
// the result strobe comes in the cycle after the last sequencer step; busy is low again then
// reset (synchronous, active low) empties the table and clears min_keep; no clearing pass
// results cannot be stalled; cfg_ready is always high
module keyed_record_table_core import krt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic [4:0] min_keep_r;
  mem_req_t   mem_req;
  rec_t       mem_rdata;

  // deletes are refused while the count is at or below this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_keep_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_keep_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // sequencer and result register
  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .min_keep  (min_keep_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // rows kept newest first at index 0
  krt_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // a new command never produces a result in the cycle right after it is taken
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("result strobe right after command beat");

  // the final result of a command comes with the block ready again
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_item |-> !busy)
    else $error("busy still high on final result");

  // a list result that is not the last keeps the block busy
  a_list_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_item |-> busy)
    else $error("list stopped before its last beat");

  // reported count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CMP_W'(out_data.used_count) <= CMP_W'(CAPACITY))
    else $error("used_count beyond capacity");

endmodule

[test/krt_table_monitor.sv]
`timescale 1ns / 1ps
// scoreboard for the keyed record table: keeps its own copy of the table,
// predicts every result beat and compares it with the block; needs krt_pkg
module krt_table_monitor import krt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_t        in_data,
  input  logic       out_valid,
  input  out_t       out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  rec_t       rows [CAPACITY];
  int         held;
  logic [4:0] keep_floor;
  out_t       expected_q [$];
  out_t       want;

  function automatic out_t blank_beat(status_t st, logic last);
    out_t b;
    b = '0;
    b.status     = st;
    b.used_count = (held > 31) ? 5'd31 : 5'(held);
    b.is_full    = (held >= CAPACITY);
    b.last_item  = last;
    return b;
  endfunction

  function automatic int find_row(logic [31:0] key);
    for (int i = 0; i < held; i++) begin
      if (rows[i].key == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_table_op(in_t op);
    int   pos;
    out_t b;
    pos = find_row(op.key_id);
    case (op.mode)
      MODE_ADD: begin
        if (held >= CAPACITY) begin
          expected_q.push_back(blank_beat(ST_FULL, 1'b1));
        end else if (pos >= 0) begin
          expected_q.push_back(blank_beat(ST_DUP, 1'b1));
        end else begin
          for (int i = held; i > 0; i--) rows[i] = rows[i-1];
          rows[0].key      = op.key_id;
          rows[0].year     = op.in_year;
          rows[0].grade_a  = op.in_grade_a;
          rows[0].grade_b  = op.in_grade_b;
          rows[0].grade_c  = op.in_grade_c;
          rows[0].course_a = op.in_course_a;
          rows[0].course_b = op.in_course_b;
          rows[0].course_c = op.in_course_c;
          held++;
          expected_q.push_back(blank_beat(ST_OK, 1'b1));
        end
      end
      MODE_DEL: begin
        if (held == 0) begin
          expected_q.push_back(blank_beat(ST_EMPTY, 1'b1));
        end else if (held <= int'(keep_floor)) begin
          expected_q.push_back(blank_beat(ST_AT_MIN, 1'b1));
        end else if (pos < 0) begin
          expected_q.push_back(blank_beat(ST_NOT_FOUND, 1'b1));
        end else begin
          for (int i = pos; i + 1 < held; i++) rows[i] = rows[i+1];
          held--;
          expected_q.push_back(blank_beat(ST_OK, 1'b1));
        end
      end
      MODE_READ: begin
        if (pos < 0) begin
          expected_q.push_back(blank_beat(ST_NOT_FOUND, 1'b1));
        end else begin
          b = blank_beat(ST_OK, 1'b1);
          b.out_id       = rows[pos].key;
          b.out_year     = rows[pos].year;
          b.out_course_a = rows[pos].course_a;
          b.out_grade_a  = rows[pos].grade_a;
          b.out_course_b = rows[pos].course_b;
          b.out_grade_b  = rows[pos].grade_b;
          b.out_course_c = rows[pos].course_c;
          b.out_grade_c  = rows[pos].grade_c;
          expected_q.push_back(b);
        end
      end
      default: begin
        if (held == 0) begin
          expected_q.push_back(blank_beat(ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < held; i++) begin
            b = blank_beat(ST_OK, i + 1 == held);
            b.out_id = rows[i].key;
            expected_q.push_back(b);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("krt: %s expected %0h got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held       = 0;
      keep_floor = '0;
      expected_q.delete();
    end else begin
      // a result beat at this edge always belongs to an earlier command
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("krt: result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status",       want.status,       out_data.status);
          check_field("used_count",   want.used_count,   out_data.used_count);
          check_field("is_full",      want.is_full,      out_data.is_full);
          check_field("out_id",       want.out_id,       out_data.out_id);
          check_field("out_year",     want.out_year,     out_data.out_year);
          check_field("out_course_a", want.out_course_a, out_data.out_course_a);
          check_field("out_grade_a",  want.out_grade_a,  out_data.out_grade_a);
          check_field("out_course_b", want.out_course_b, out_data.out_course_b);
          check_field("out_grade_b",  want.out_grade_b,  out_data.out_grade_b);
          check_field("out_course_c", want.out_course_c, out_data.out_course_c);
          check_field("out_grade_c",  want.out_grade_c,  out_data.out_grade_c);
          check_field("last_item",    want.last_item,    out_data.last_item);
        end
      end
      if (cfg_valid && cfg_ready) keep_floor = cfg_data;
      if (start && !busy) apply_table_op(in_data);
    end
    pending = expected_q.size();
  end

endmodule

[test/tb_keyed_record_table_core.sv]
`timescale 1ns / 1ps
// stimulus and verdict for keyed_record_table_core: directed commands, then
// random phases under several min_keep settings; needs krt_pkg, krt_table_monitor
module tb_keyed_record_table_core;
  import krt_pkg::*;

  localparam int POOL_SIZE   = 24;  // more keys than rows, so adds hit full and duplicate
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 55;
  localparam int SETTLE      = 40;  // a little above the slowest command at full table

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_data;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [4:0] cfg_data;
  int         fail_count;
  int         pending;

  logic [31:0] key_pool [POOL_SIZE];
  logic [4:0]  keep_plan [PHASES] = '{5'd16, 5'd0, 5'd7, 5'd1, 5'd15, 5'd3, 5'd0, 5'd12};
  bit          idling_on;
  in_t         item;

  keyed_record_table_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  krt_table_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tb_keyed_record_table_core: done, errors");
    $finish;
  end

  // one command beat: raise start at a falling edge, hold until taken
  // returns at the falling edge after the beat, start still high
  task automatic send_beat(in_t cmd);
    start   = 1'b1;
    in_data = cmd;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // min_keep write on its own channel
  task automatic write_keep(logic [4:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending until every predicted beat has come, then let the block settle
  task automatic drain_and_settle();
    start = 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (SETTLE) @(negedge clk);
  endtask

  // command with a random record body
  function automatic in_t make_cmd(mode_t m, logic [31:0] key);
    in_t c;
    c.mode        = m;
    c.key_id      = key;
    c.in_year     = 8'($urandom);
    c.in_course_a = 16'($urandom);
    c.in_grade_a  = 8'($urandom);
    c.in_course_b = 16'($urandom);
    c.in_grade_b  = 8'($urandom);
    c.in_course_c = 16'($urandom);
    c.in_grade_c  = 8'($urandom);
    return c;
  endfunction

  // random command: weights in percent for add, delete and read, list takes the rest
  // most keys come from the pool so hits are common, the rest are stray keys
  function automatic in_t random_cmd(int add_w, int del_w, int read_w);
    int          roll;
    mode_t       m;
    logic [31:0] key;
    roll = $urandom_range(99);
    if (roll < add_w)                       m = MODE_ADD;
    else if (roll < add_w + del_w)          m = MODE_DEL;
    else if (roll < add_w + del_w + read_w) m = MODE_READ;
    else                                    m = MODE_LIST;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else                         key = $urandom;
    return make_cmd(m, key);
  endfunction

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idling_on = 1'b1;

    // key extremes first, then random keys
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // empty table: list reports empty, delete reports empty, read misses
    send_beat(make_cmd(MODE_LIST, key_pool[0]));
    send_beat(make_cmd(MODE_DEL, key_pool[0]));
    send_beat(make_cmd(MODE_READ, key_pool[1]));

    // all-zero and all-one records
    item      = '0;
    item.mode = MODE_ADD;
    send_beat(item);
    item      = '1;
    item.mode = MODE_ADD;
    send_beat(item);

    // duplicate key leaves the table alone
    send_beat(make_cmd(MODE_ADD, key_pool[1]));
    send_beat(make_cmd(MODE_READ, key_pool[0]));
    send_beat(make_cmd(MODE_READ, key_pool[1]));
    // key not held: read and delete both miss
    send_beat(make_cmd(MODE_READ, key_pool[2]));
    send_beat(make_cmd(MODE_DEL, key_pool[2]));
    send_beat(make_cmd(MODE_LIST, key_pool[0]));

    // count equal to min_keep refuses the delete
    drain_and_settle();
    write_keep(5'd2);
    send_beat(make_cmd(MODE_DEL, key_pool[0]));
    drain_and_settle();
    write_keep(5'd0);

    // fill up to capacity
    for (int i = 2; i < CAPACITY; i++) send_beat(make_cmd(MODE_ADD, key_pool[i]));
    // full table: the full check wins over the duplicate check
    send_beat(make_cmd(MODE_ADD, key_pool[3]));
    send_beat(make_cmd(MODE_ADD, key_pool[20]));
    send_beat(make_cmd(MODE_LIST, key_pool[0]));
    // delete from the middle keeps the order of the rest
    send_beat(make_cmd(MODE_DEL, key_pool[9]));
    send_beat(make_cmd(MODE_READ, key_pool[10]));
    send_beat(make_cmd(MODE_LIST, key_pool[0]));

    // ---- random phases ----
    // even phases drain the table, odd phases fill it; min_keep changes each time
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_keep(keep_plan[p]);
      idling_on = (p != 3);  // one long stretch with back-to-back commands
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // once, hold off mid-phase until the block has answered everything
        if (p == 5 && n == PHASE_BEATS / 2) drain_and_settle();
        if (idling_on && $urandom_range(99) < 30) begin
          start = 1'b0;
          repeat ($urandom_range(($urandom_range(3) == 0) ? 40 : 3, 1)) @(negedge clk);
        end
        if (p % 2 == 0) send_beat(random_cmd(15, 55, 20));
        else            send_beat(random_cmd(50, 15, 20));
      end
    end

    drain_and_settle();
    if (fail_count == 0) begin
      $display("tb_keyed_record_table_core: done, clean");
    end else begin
      $display("tb_keyed_record_table_core: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
design/krt_pkg.sv
design/krt_mem.sv
design/krt_ctrl.sv
design/keyed_record_table_core.sv
test/krt_table_monitor.sv
test/tb_keyed_record_table_core.sv
